// ===== sv/tis_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle isoline segment package
// Shared types, widths and codes for the contour segment pipeline.
// ----------------------------------------------------------------------------
package tis_pkg;

  // Word width of every coordinate and scalar.
  localparam int DW = 32;
  // Width of the tolerance register.
  localparam int TW = DW - 1;
  // Width of the exact product of two magnitudes.
  localparam int MW = 2 * DW;
  // Quotient bits kept; a larger quotient always saturates.
  localparam int QW = 41;
  // High numerator bits that seed the divider remainder.
  localparam int HW = MW + 1 - QW;
  // Register stages inside one interpolation lane.
  localparam int LANE_LAT = QW + 4;

  typedef logic signed [DW-1:0] word_t;

  // Configuration register indexes.
  localparam logic REG_ISO_LEVEL = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  // Class of a vertex against the level.
  typedef enum logic [1:0] {
    CLS_ON    = 2'b00,
    CLS_ABOVE = 2'b01,
    CLS_BELOW = 2'b10
  } cls_t;

  typedef struct packed {
    word_t ax_in;
    word_t ay_in;
    word_t az_in;
    word_t a_value;
    word_t bx_in;
    word_t by_in;
    word_t bz_in;
    word_t b_value;
    word_t cx_in;
    word_t cy_in;
    word_t cz_in;
    word_t c_value;
  } in_item_t;

  typedef struct packed {
    word_t start_x;
    word_t start_y;
    word_t start_z;
    word_t end_x;
    word_t end_y;
    word_t end_z;
  } out_item_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t f;
  } vtx_t;

  typedef struct packed {
    vtx_t p;
    vtx_t q;
  } edge_t;

  typedef struct packed {
    edge_t e1;
    edge_t e2;
  } seg_t;

  // Magnitude of a widened signed difference.
  function automatic logic [DW:0] mag_w(logic [DW:0] v);
    return v[DW] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== sv/tis_select.sv =====
// ----------------------------------------------------------------------------
// Triangle isoline segment: vertex classing and edge selection
// Classes each vertex against the level and registers the two chosen edges.
// ----------------------------------------------------------------------------
module tis_select import tis_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  in_item_t      item,
  input  word_t         iso_level,
  input  logic [TW-1:0] tolerance,
  output logic          valid_r,
  output seg_t          seg_r
);

  // A vertex inside the tolerance band counts as on the level. With an empty
  // band only an exact match with the level is on it.
  function automatic cls_t classify(word_t f, word_t lvl, logic [TW-1:0] tol);
    logic [DW:0] d;
    logic [DW:0] m;
    d = {f[DW-1], f} - {lvl[DW-1], lvl};
    m = mag_w(d);
    if (m < {2'b00, tol} || d == '0) begin
      return CLS_ON;
    end else if (d[DW]) begin
      return CLS_BELOW;
    end
    return CLS_ABOVE;
  endfunction

  vtx_t va, vb, vc;
  cls_t sa, sb, sc;
  logic hit;
  seg_t seg_nxt;
  logic valid_nxt;

  assign va = {item.ax_in, item.ay_in, item.az_in, item.a_value};
  assign vb = {item.bx_in, item.by_in, item.bz_in, item.b_value};
  assign vc = {item.cx_in, item.cy_in, item.cz_in, item.c_value};

  assign sa = classify(item.a_value, iso_level, tolerance);
  assign sb = classify(item.b_value, iso_level, tolerance);
  assign sc = classify(item.c_value, iso_level, tolerance);

  // The first vertex whose class differs from both others picks the edges.
  always_comb begin
    hit = 1'b1;
    seg_nxt.e1 = '{p: va, q: vb};
    seg_nxt.e2 = '{p: va, q: vc};
    priority if (sa != sb && sa != sc) begin
      seg_nxt.e1 = '{p: va, q: vb};
      seg_nxt.e2 = '{p: va, q: vc};
    end else if (sa != sb && sb != sc) begin
      seg_nxt.e1 = '{p: va, q: vb};
      seg_nxt.e2 = '{p: vb, q: vc};
    end else if (sa != sc && sb != sc) begin
      seg_nxt.e1 = '{p: va, q: vc};
      seg_nxt.e2 = '{p: vb, q: vc};
    end else begin
      hit = 1'b0;
    end
  end

  assign valid_nxt = in_valid && hit;

  // Triangles that give no segment drop out here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r <= seg_nxt;
    end
  end

endmodule

// ===== sv/tis_lane.sv =====
// ----------------------------------------------------------------------------
// Triangle isoline segment: one interpolation lane
// Computes one crossing coordinate cp + round((cq-cp)*(lvl-fp)/(fq-fp)),
// saturated, through a multiply stage and a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
module tis_lane import tis_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t iso_level,
  input  word_t cp,
  input  word_t cq,
  input  word_t fp,
  input  word_t fq,
  output word_t coord_r
);

  localparam int SW = QW + 2;
  localparam word_t MAXV = {1'b0, {(DW - 1){1'b1}}};
  localparam word_t MINV = {1'b1, {(DW - 1){1'b0}}};

  // Differences, magnitudes and the result sign.
  logic [DW:0] n_w, d_w, c_w, n_m, d_m, c_m;
  logic [DW-1:0] a_nmag_r, a_cmag_r, a_den_r;
  logic a_neg_r, a_zero_r;
  word_t a_cp_r;

  assign n_w = {iso_level[DW-1], iso_level} - {fp[DW-1], fp};
  assign d_w = {fq[DW-1], fq} - {fp[DW-1], fp};
  assign c_w = {cq[DW-1], cq} - {cp[DW-1], cp};
  assign n_m = mag_w(n_w);
  assign d_m = mag_w(d_w);
  assign c_m = mag_w(c_w);

  always_ff @(posedge clk) begin
    if (en) begin
      a_nmag_r <= n_m[DW-1:0];
      a_cmag_r <= c_m[DW-1:0];
      a_den_r  <= d_m[DW-1:0];
      a_neg_r  <= n_w[DW] ^ d_w[DW] ^ c_w[DW];
      a_zero_r <= (d_w == '0);
      a_cp_r   <= cp;
    end
  end

  // Exact product of the magnitudes.
  logic [MW-1:0] b_prod_r;
  logic [DW-1:0] b_den_r;
  logic b_neg_r, b_zero_r;
  word_t b_cp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod_r <= a_nmag_r * a_cmag_r;
      b_den_r  <= a_den_r;
      b_neg_r  <= a_neg_r;
      b_zero_r <= a_zero_r;
      b_cp_r   <= a_cp_r;
    end
  end

  // Rounding offset, early saturation test and divider seed.
  logic [MW:0] num;
  logic [HW-1:0] hi;
  logic [DW-1:0] rem_r [0:QW];
  logic [QW-1:0] acc_r [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic neg_r [0:QW];
  logic zero_r [0:QW];
  logic sat_r [0:QW];
  word_t cp_r [0:QW];

  assign num = {1'b0, b_prod_r} + {{(MW + 1 - (DW - 1)){1'b0}}, b_den_r[DW-1:1]};
  assign hi = num[MW:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {{(DW - HW){1'b0}}, hi};
      acc_r[0]  <= num[QW-1:0];
      den_r[0]  <= b_den_r;
      neg_r[0]  <= b_neg_r;
      zero_r[0] <= b_zero_r;
      sat_r[0]  <= ({{(DW - HW){1'b0}}, hi} >= b_den_r);
      cp_r[0]   <= b_cp_r;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] t;
    logic [DW:0] diff;
    logic ge;

    assign t = {rem_r[k], acc_r[k][QW-1]};
    assign diff = t - {1'b0, den_r[k]};
    assign ge = (t >= {1'b0, den_r[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        acc_r[k+1]  <= {acc_r[k][QW-2:0], ge};
        den_r[k+1]  <= den_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        sat_r[k+1]  <= sat_r[k];
        cp_r[k+1]   <= cp_r[k];
      end
    end
  end

  // Apply the signed offset and clamp to the word range.
  logic signed [SW-1:0] cpe, qe, sum;
  word_t coord_nxt;

  assign cpe = {{(SW - DW){cp_r[QW][DW-1]}}, cp_r[QW]};
  assign qe = {2'b00, acc_r[QW]};
  assign sum = neg_r[QW] ? (cpe - qe) : (cpe + qe);

  always_comb begin
    if (zero_r[QW]) begin
      coord_nxt = cp_r[QW];
    end else if (sat_r[QW]) begin
      coord_nxt = neg_r[QW] ? MINV : MAXV;
    end else if (sum[SW-1:DW-1] != {(SW - DW + 1){sum[SW-1]}}) begin
      coord_nxt = sum[SW-1] ? MINV : MAXV;
    end else begin
      coord_nxt = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord_r <= coord_nxt;
    end
  end

endmodule

// ===== sv/triangle_isoline_segment_top.sv =====
// ----------------------------------------------------------------------------
// Triangle isoline segment top level
// Marching-triangles contour step: one triangle in, at most one segment out.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one triangle item per cycle (three vertices with
//   x, y, z and a scalar, Q16.16). Each item that crosses the level leaves on
//   the output channel as one segment item; others give no item.
//   The configuration channel writes iso_level (index 0) and tolerance
//   (index 1); cfg_ready is always high. Write it only while the pipe is empty.
//   From acceptance to out_valid, one stage classes the vertices and picks
//   the edges, then six parallel lanes each spend one stage on differences,
//   one on the 32x32 multiply, one on rounding, 41 on the one-bit-per-stage
//   divider and one on the final add and clamp.
//   Throughput is one item per cycle while the receiver does not stall.
//   When the receiver stalls with a segment waiting, the whole pipe holds and
//   in_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits, sets iso_level to 0 and tolerance to 1.
// ----------------------------------------------------------------------------
module triangle_isoline_segment_top import tis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  word_t     cfg_data
);

  logic en;
  word_t iso_level_r;
  logic [TW-1:0] tolerance_r;
  logic sel_valid;
  seg_t seg;
  logic [LANE_LAT-1:0] valid_r;
  edge_t ed [0:1];
  word_t res [0:5];

  // The pipe moves whenever the output register is free or being taken.
  assign en = out_ready || !out_valid;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_level_r <= '0;
      tolerance_r <= {{(TW - 1){1'b0}}, 1'b1};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ISO_LEVEL: iso_level_r <= cfg_data;
        REG_TOLERANCE: tolerance_r <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  tis_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .item      (in_data),
    .iso_level (iso_level_r),
    .tolerance (tolerance_r),
    .valid_r   (sel_valid),
    .seg_r     (seg)
  );

  assign ed[0] = seg.e1;
  assign ed[1] = seg.e2;

  // Six lanes: x, y, z of the start point, then of the end point.
  for (genvar e = 0; e < 2; e++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_coord
      word_t cp, cq;
      if (k == 0) begin : g_x
        assign cp = ed[e].p.x;
        assign cq = ed[e].q.x;
      end else if (k == 1) begin : g_y
        assign cp = ed[e].p.y;
        assign cq = ed[e].q.y;
      end else begin : g_z
        assign cp = ed[e].p.z;
        assign cq = ed[e].q.z;
      end

      tis_lane u_lane (
        .clk       (clk),
        .en        (en),
        .iso_level (iso_level_r),
        .cp        (cp),
        .cq        (cq),
        .fp        (ed[e].p.f),
        .fq        (ed[e].q.f),
        .coord_r   (res[e * 3 + k])
      );
    end
  end

  // Valid bits travel alongside the lane stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LANE_LAT-2:0], sel_valid};
    end
  end

  assign out_valid = valid_r[LANE_LAT-1];
  assign out_data = '{start_x: res[0], start_y: res[1], start_z: res[2],
                      end_x: res[3], end_y: res[4], end_z: res[5]};

endmodule

// ===== sv/tis_checker.sv =====
// ----------------------------------------------------------------------------
// Triangle isoline segment checker
// Port-level assertions on the pipeline handshake, bound to the top level.
// ----------------------------------------------------------------------------
module tis_checker import tis_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled segment holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // The input side stalls exactly when a finished segment is held back.
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("in_ready does not follow the output stall");

  // No item can come out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Back pressure only ever comes from a waiting segment.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no output item waiting");

endmodule

bind triangle_isoline_segment_top tis_checker u_tis_checker (.*);

// ===== tb/triangle_isoline_segment_top_tb.sv =====
// ----------------------------------------------------------------------------
// Triangle isoline segment testbench
// Drives triangles through the contour step under several level and band
// settings. A model inside the bench predicts each segment, and every segment
// that leaves the block is checked against it, field by field, in order.
// ----------------------------------------------------------------------------
module triangle_isoline_segment_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tis_pkg::*;

  localparam int  STALL_LIMIT = 4000;
  localparam int  DRAIN_CYCLES = 60;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  word_t     cfg_data;

  triangle_isoline_segment_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Bench copy of the configuration registers.
  longint    level_now;
  longint    band_now;

  in_item_t  triangle_q[$];
  out_item_t segment_q[$];
  bit        in_taken;
  bit        calm;
  int        stall_cycles;
  int        mismatches;
  int        n_triangles;
  int        n_segments;
  int        n_phases;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Class of one scalar against the current level and band. An exact match
  // is on the level even when the band is empty.
  function automatic cls_t vertex_class(word_t f);
    longint d;
    longint ad;
    d  = longint'(f) - level_now;
    ad = (d < 0) ? -d : d;
    if (ad < band_now || d == 0) return CLS_ON;
    return (d > 0) ? CLS_ABOVE : CLS_BELOW;
  endfunction

  // One coordinate of the crossing on edge p->q, rounded and clamped.
  function automatic word_t cross_coord(word_t cp, word_t cq, word_t fp, word_t fq);
    longint          n;
    longint          d;
    longint          dc;
    longint          r;
    longint unsigned den;
    longint unsigned prod;
    longint unsigned quo;
    bit              neg;
    n  = level_now - longint'(fp);
    d  = longint'(fq) - longint'(fp);
    dc = longint'(cq) - longint'(cp);
    if (d == 0) return cp;
    den  = (d < 0) ? -d : d;
    prod = longint'((n < 0) ? -n : n) * longint'((dc < 0) ? -dc : dc);
    quo  = (prod + den / 2) / den;
    neg  = (((n < 0) != (d < 0)) != (dc < 0)) && quo != 0;
    if (quo > (64'd1 << 40)) return neg ? word_t'(WMIN) : word_t'(WMAX);
    r = neg ? longint'(cp) - longint'(quo) : longint'(cp) + longint'(quo);
    if (r > WMAX) r = WMAX;
    if (r < WMIN) r = WMIN;
    return word_t'(r);
  endfunction

  function automatic vtx_t corner(in_item_t t, int k);
    vtx_t v;
    case (k)
      0:       v = '{t.ax_in, t.ay_in, t.az_in, t.a_value};
      1:       v = '{t.bx_in, t.by_in, t.bz_in, t.b_value};
      default: v = '{t.cx_in, t.cy_in, t.cz_in, t.c_value};
    endcase
    return v;
  endfunction

  function automatic vtx_t crossing(vtx_t p, vtx_t q);
    vtx_t r;
    r.x = cross_coord(p.x, q.x, p.f, q.f);
    r.y = cross_coord(p.y, q.y, p.f, q.f);
    r.z = cross_coord(p.z, q.z, p.f, q.f);
    r.f = '0;
    return r;
  endfunction

  // Picks the edge pair of a triangle and places the segment on it.
  function automatic bit predict_segment(in_item_t t, output out_item_t s);
    vtx_t a, b, c, s0, s1;
    cls_t ka, kb, kc;
    a = corner(t, 0);
    b = corner(t, 1);
    c = corner(t, 2);
    ka = vertex_class(a.f);
    kb = vertex_class(b.f);
    kc = vertex_class(c.f);
    s = '0;
    if (ka != kb && ka != kc) begin
      s0 = crossing(a, b);
      s1 = crossing(a, c);
    end else if (ka != kb && kb != kc) begin
      s0 = crossing(a, b);
      s1 = crossing(b, c);
    end else if (ka != kc && kb != kc) begin
      s0 = crossing(a, c);
      s1 = crossing(b, c);
    end else begin
      return 1'b0;
    end
    s = '{s0.x, s0.y, s0.z, s1.x, s1.y, s1.z};
    return 1'b1;
  endfunction

  // Scalar of the asked class: on the band, above it, or below it.
  function automatic word_t scalar_of(cls_t k);
    longint v;
    longint span;
    span = (band_now > 0) ? band_now - 1 : 0;
    case (k)
      CLS_ON:    v = level_now + longint'($urandom_range(2 * 1024)) % (2 * span + 1) - span;
      CLS_ABOVE: v = level_now + band_now + (($urandom_range(3) == 0) ?
                     longint'($urandom) : longint'($urandom_range(1 << 20)));
      default:   v = level_now - band_now - (($urandom_range(3) == 0) ?
                     longint'($urandom) : longint'($urandom_range(1 << 20)));
    endcase
    if (v > WMAX) v = WMAX;
    if (v < WMIN) v = WMIN;
    return word_t'(v);
  endfunction

  function automatic word_t coord_rand();
    return ($urandom_range(2) == 0) ? word_t'($urandom) :
           word_t'($urandom_range(1 << 22)) - word_t'(1 << 21);
  endfunction

  function automatic in_item_t triangle_rand();
    in_item_t t;
    cls_t     k[3];
    for (int i = 0; i < 3; i++) begin
      k[i] = cls_t'($urandom_range(2));
    end
    t = '{coord_rand(), coord_rand(), coord_rand(), scalar_of(k[0]),
          coord_rand(), coord_rand(), coord_rand(), scalar_of(k[1]),
          coord_rand(), coord_rand(), coord_rand(), scalar_of(k[2])};
    // A few triangles carry raw scalars anywhere in the range.
    if ($urandom_range(9) == 0) begin
      t.a_value = $urandom;
      t.b_value = $urandom;
      t.c_value = $urandom;
    end
    return t;
  endfunction

  function automatic in_item_t triangle_fixed(cls_t ka, cls_t kb, cls_t kc, word_t xy);
    return '{xy, -xy, word_t'(0), scalar_of(ka),
             -xy, xy, word_t'(WMAX), scalar_of(kb),
             word_t'(WMIN), word_t'(WMAX), -xy, scalar_of(kc)};
  endfunction

  task automatic write_reg(logic idx, word_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ISO_LEVEL) level_now = longint'(val);
    else band_now = longint'(val[TW-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One setting of the registers, its triangles, then a full drain.
  task automatic run_phase(word_t lvl, word_t band, int n_rand, bit directed, bit quiet);
    write_reg(REG_ISO_LEVEL, lvl);
    write_reg(REG_TOLERANCE, band);
    calm = quiet;
    n_phases++;
    if (directed) begin
      // Wholly above, below and on the level give nothing.
      triangle_q.push_back(triangle_fixed(CLS_ABOVE, CLS_ABOVE, CLS_ABOVE, 32'h100));
      triangle_q.push_back(triangle_fixed(CLS_BELOW, CLS_BELOW, CLS_BELOW, 32'h100));
      triangle_q.push_back(triangle_fixed(CLS_ON, CLS_ON, CLS_ON, 32'h100));
      // The lone vertex in each position selects each edge pair.
      triangle_q.push_back(triangle_fixed(CLS_ABOVE, CLS_BELOW, CLS_BELOW, 32'h10000));
      triangle_q.push_back(triangle_fixed(CLS_BELOW, CLS_ABOVE, CLS_BELOW, 32'h10000));
      triangle_q.push_back(triangle_fixed(CLS_BELOW, CLS_BELOW, CLS_ABOVE, 32'h10000));
      // A vertex inside the band pushes the crossing off the edge.
      triangle_q.push_back(triangle_fixed(CLS_ON, CLS_ABOVE, CLS_BELOW, word_t'(WMAX)));
      triangle_q.push_back(triangle_fixed(CLS_ABOVE, CLS_ON, CLS_BELOW, word_t'(WMIN)));
      triangle_q.push_back(triangle_fixed(CLS_ABOVE, CLS_BELOW, CLS_ON, 32'h7fff0000));
      triangle_q.push_back(triangle_fixed(CLS_ON, CLS_ON, CLS_ABOVE, 32'h1));
      // Field extremes.
      triangle_q.push_back('{12{word_t'(WMAX)}});
      triangle_q.push_back('{12{word_t'(WMIN)}});
      triangle_q.push_back('{word_t'(WMIN), word_t'(WMIN), word_t'(WMIN), word_t'(WMIN),
                             word_t'(WMAX), word_t'(WMAX), word_t'(WMAX), word_t'(WMAX),
                             word_t'(WMIN), word_t'(WMAX), word_t'(0), word_t'(WMAX)});
      triangle_q.push_back('{word_t'(WMAX), word_t'(WMAX), word_t'(WMAX), word_t'(WMAX),
                             word_t'(WMIN), word_t'(WMIN), word_t'(WMIN), word_t'(WMIN),
                             word_t'(0), word_t'(-1), word_t'(1), word_t'(WMIN)});
      triangle_q.push_back('{word_t'(-1), word_t'(1), word_t'(0), word_t'(1),
                             word_t'(1), word_t'(-1), word_t'(0), word_t'(-1),
                             word_t'(0), word_t'(0), word_t'(-1), word_t'(0)});
    end
    for (int i = 0; i < n_rand; i++) begin
      triangle_q.push_back(triangle_rand());
    end
    do @(posedge clk); while (triangle_q.size() != 0 || in_valid || segment_q.size() != 0);
    // Triangles that make no segment may still be in the pipe.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Triangle driver.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (triangle_q.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
        in_data  <= triangle_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= calm || ($urandom_range(99) >= 6);
  end

  // Prediction on accepted triangles, checking of segments, watchdog.
  always @(posedge clk) begin
    out_item_t s;
    out_item_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      stall_cycles++;
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        stall_cycles = 0;
        n_triangles++;
        if (predict_segment(in_data, s)) segment_q.push_back(s);
      end
      if (cfg_valid && cfg_ready) stall_cycles = 0;
      if (out_valid && out_ready) begin
        stall_cycles = 0;
        n_segments++;
        if (segment_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected segment %h", out_data);
        end else begin
          want = segment_q.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (want[(5-k)*DW +: DW] !== out_data[(5-k)*DW +: DW]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("segment %0d field %0d: expected %h, got %h", n_segments, k,
                         want[(5-k)*DW +: DW], out_data[(5-k)*DW +: DW]);
            end
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ISO_LEVEL;
    cfg_data = '0;
    level_now = 0;
    band_now = 1;
    calm = 1'b0;
    in_taken = 1'b0;
    stall_cycles = 0;
    mismatches = 0;
    n_triangles = 0;
    n_segments = 0;
    n_phases = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_phase(32'sd0, 32'sd1, 100, 1'b1, 1'b0);
    run_phase(32'sh00010000, 32'sh00008000, 140, 1'b1, 1'b0);
    run_phase(word_t'(WMIN), 32'sh7fffffff, 120, 1'b1, 1'b0);
    // Bit 31 set with low bits clear gives an empty band.
    run_phase(word_t'(WMAX), 32'sh80000000, 120, 1'b1, 1'b0);
    run_phase(word_t'($urandom), 32'sh00000100, 160, 1'b0, 1'b1);
    run_phase(32'shfff80000, word_t'($urandom_range(1 << 24, 1)), 160, 1'b0, 1'b0);

    if (segment_q.size() != 0) begin
      mismatches++;
      $display("%0d segments never arrived", segment_q.size());
    end
    $display("covered %0d triangles, %0d segments over %0d register settings",
             n_triangles, n_segments, n_phases);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
